// ===== rtl/core/itr_pkg.sv =====
// Shared types, constants and letter tables for the Roman numeral converter.
package itr_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned SymW   = 7;
  localparam int unsigned DigW   = 4;
  localparam int unsigned WideW  = 14;

  localparam logic [ValueW-1:0] VALUE_MAX = 12'd3999;

  // Place indexes, most significant first
  localparam logic [1:0] PLACE_THOUSANDS = 2'd0;
  localparam logic [1:0] PLACE_HUNDREDS  = 2'd1;
  localparam logic [1:0] PLACE_TENS      = 2'd2;
  localparam logic [1:0] PLACE_ONES      = 2'd3;

  localparam logic [SymW-1:0] ASCII_I = 7'h49;
  localparam logic [SymW-1:0] ASCII_V = 7'h56;
  localparam logic [SymW-1:0] ASCII_X = 7'h58;
  localparam logic [SymW-1:0] ASCII_L = 7'h4C;
  localparam logic [SymW-1:0] ASCII_C = 7'h43;
  localparam logic [SymW-1:0] ASCII_D = 7'h44;
  localparam logic [SymW-1:0] ASCII_M = 7'h4D;
  localparam logic [SymW-1:0] ASCII_NUL = 7'h00;

  typedef enum logic [1:0] {
    KIND_UNIT,
    KIND_FIVE,
    KIND_TEN
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       split;
    logic       emit;
    logic       emit_inv;
    logic [1:0] place;
    logic [1:0] step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       invalid;
    logic [2:0] len;
    logic       step_end;
    logic       last_letter;
  } sts_t;

  function automatic logic [WideW-1:0] place_weight(input logic [1:0] place);
    logic [WideW-1:0] w;
    unique case (place)
      PLACE_THOUSANDS: w = 14'd1000;
      PLACE_HUNDREDS:  w = 14'd100;
      PLACE_TENS:      w = 14'd10;
      default:         w = 14'd1;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] pattern_len(input logic [DigW-1:0] d);
    logic [2:0] n;
    case (d) inside
      4'd1, 4'd5:        n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:        n = 3'd3;
      4'd8:              n = 3'd4;
      default:           n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic kind_e pattern_kind(input logic [DigW-1:0] d, input logic [1:0] step);
    kind_e k;
    case (d) inside
      4'd4:             k = (step == 2'd0) ? KIND_UNIT : KIND_FIVE;
      4'd5:             k = KIND_FIVE;
      4'd6, 4'd7, 4'd8: k = (step == 2'd0) ? KIND_FIVE : KIND_UNIT;
      4'd9:             k = (step == 2'd0) ? KIND_UNIT : KIND_TEN;
      default:          k = KIND_UNIT;
    endcase
    return k;
  endfunction

  function automatic logic [SymW-1:0] place_letter(input logic [1:0] place, input kind_e kind);
    logic [SymW-1:0] s;
    unique case (place)
      PLACE_THOUSANDS: s = ASCII_M;
      PLACE_HUNDREDS: begin
        s = (kind == KIND_UNIT) ? ASCII_C : (kind == KIND_FIVE) ? ASCII_D : ASCII_M;
      end
      PLACE_TENS: begin
        s = (kind == KIND_UNIT) ? ASCII_X : (kind == KIND_FIVE) ? ASCII_L : ASCII_C;
      end
      default: begin
        s = (kind == KIND_UNIT) ? ASCII_I : (kind == KIND_FIVE) ? ASCII_V : ASCII_X;
      end
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/itr_datapath.sv =====
// Datapath: decimal place split, letter lookup and output register.
module itr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [itr_pkg::ValueW-1:0]    value_i,
  input  itr_pkg::cmd_t                 cmd_i,
  output itr_pkg::sts_t                 sts_o,
  output logic [itr_pkg::SymW-1:0]      symbol_o,
  output logic                          invalid_o,
  output logic                          last_o
);
  import itr_pkg::*;

  logic [ValueW-1:0] rem_q, rem_d;
  logic [DigW-1:0]   dig_q [4];
  logic [SymW-1:0]   sym_q;
  logic              inv_q;
  logic              last_q;

  logic [WideW-1:0]  weight;
  logic [8:0]        ge;
  logic [DigW-1:0]   digit;
  logic [WideW-1:0]  sub;
  logic [DigW-1:0]   cur_dig;
  logic              rest_zero;
  logic [SymW-1:0]   letter;

  // Count how many multiples of the place weight fit into the remainder
  always_comb begin
    weight = place_weight(cmd_i.place);
    for (int k = 1; k <= 9; k++) begin
      ge[k-1] = ({2'b00, rem_q} >= (WideW'(k) * weight));
    end
    digit = DigW'($countones(ge));
    sub   = {2'b00, rem_q} - (WideW'(digit) * weight);
    rem_d = sub[ValueW-1:0];
  end

  always_comb begin
    cur_dig = dig_q[cmd_i.place];
    unique case (cmd_i.place)
      PLACE_THOUSANDS: rest_zero = (dig_q[1] == '0) && (dig_q[2] == '0) && (dig_q[3] == '0);
      PLACE_HUNDREDS:  rest_zero = (dig_q[2] == '0) && (dig_q[3] == '0);
      PLACE_TENS:      rest_zero = (dig_q[3] == '0);
      default:         rest_zero = 1'b1;
    endcase
    if (cmd_i.place == PLACE_THOUSANDS) begin
      sts_o.len = cur_dig[2:0];
      letter    = ASCII_M;
    end else begin
      sts_o.len = pattern_len(cur_dig);
      letter    = place_letter(cmd_i.place, pattern_kind(cur_dig, cmd_i.step));
    end
    sts_o.invalid     = (rem_q == '0) || (rem_q > VALUE_MAX);
    sts_o.step_end    = (({1'b0, cmd_i.step} + 3'd1) == sts_o.len);
    sts_o.last_letter = sts_o.step_end && rest_zero;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= value_i;
    end else if (cmd_i.split) begin
      rem_q <= rem_d;
      dig_q[cmd_i.place] <= digit;
      if (cmd_i.place == PLACE_TENS) begin
        dig_q[PLACE_ONES] <= rem_d[DigW-1:0];
      end
    end
  end

  // Output payload; valid lives in the controller
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      sym_q  <= letter;
      inv_q  <= 1'b0;
      last_q <= sts_o.last_letter;
    end else if (cmd_i.emit_inv) begin
      sym_q  <= ASCII_NUL;
      inv_q  <= 1'b1;
      last_q <= 1'b1;
    end
  end

  assign symbol_o  = sym_q;
  assign invalid_o = inv_q;
  assign last_o    = last_q;

  // rst_ni is not needed by payload registers
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

// ===== rtl/core/itr_ctrl.sv =====
// Controller: sequences range check, place split and letter emission.
module itr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  itr_pkg::sts_t  sts_i,
  output itr_pkg::cmd_t  cmd_o
);
  import itr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPLIT,
    ST_EMIT
  } state_e;

  state_e     state_q;
  logic [1:0] place_q;
  logic [1:0] step_q;
  logic       out_valid_q;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.place    = place_q;
    cmd_o.step     = step_q;
    unique case (state_q)
      ST_IDLE:  cmd_o.load = in_valid_i;
      ST_CHECK: begin
        if (sts_i.invalid) begin
          cmd_o.emit_inv = out_free;
        end else begin
          cmd_o.split = 1'b1;
        end
      end
      ST_SPLIT: cmd_o.split = 1'b1;
      ST_EMIT:  cmd_o.emit  = out_free && (sts_i.len != 3'd0);
      default:  cmd_o.load  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      place_q     <= PLACE_THOUSANDS;
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit || cmd_o.emit_inv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
            place_q <= PLACE_THOUSANDS;
            step_q  <= 2'd0;
          end
        end
        ST_CHECK: begin
          if (sts_i.invalid) begin
            if (out_free) begin
              state_q <= ST_IDLE;
            end
          end else begin
            place_q <= PLACE_HUNDREDS;
            state_q <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (place_q == PLACE_TENS) begin
            place_q <= PLACE_THOUSANDS;
            state_q <= ST_EMIT;
          end else begin
            place_q <= place_q + 2'd1;
          end
        end
        ST_EMIT: begin
          if (sts_i.len == 3'd0) begin
            // skip a zero place
            place_q <= place_q + 2'd1;
          end else if (out_free) begin
            if (sts_i.last_letter) begin
              state_q <= ST_IDLE;
            end else if (sts_i.step_end) begin
              place_q <= place_q + 2'd1;
              step_q  <= 2'd0;
            end else begin
              step_q <= step_q + 2'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/integer_to_roman_numeral_top.sv =====
// Top level of the integer to Roman numeral converter.
//
// The slave stream takes one 12-bit unsigned integer per transfer in
// s_axis_tdata_i[11:0]. For values 1 to 3999 the master stream gives the
// Roman numeral one ASCII letter per transfer, most significant place
// first, with tlast on the final letter. Any other value gives a single
// transfer with tuser set, a zero letter and tlast.
// Timing: the check state checks the range and splits off the thousands
// through a compare-and-subtract unit; the split state then splits the
// hundreds, then the tens and ones. Letters then enter the output register
// at one per cycle while the receiver accepts them, and the emit state
// passes over each zero place without a letter. The invalid result is
// registered from the check state once the output register is free.
// One item is in flight at a time: tready rises again once the final
// letter is in the output register, so the next value is taken while that
// letter still waits. A stalled receiver holds the output register and
// freezes emission. Reset clears the controller and drops any pending
// output; no memory needs clearing.
module integer_to_roman_numeral_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] value, [15:12] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] symbol, [7] zero
  output logic        m_axis_tuser_o,   // [0] is_invalid
  output logic        m_axis_tlast_o
);
  import itr_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [SymW-1:0] symbol;
  logic [3:0]      unused_hi;

  assign unused_hi = s_axis_tdata_i[15:12];

  itr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  itr_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .value_i   (s_axis_tdata_i[ValueW-1:0]),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .symbol_o  (symbol),
    .invalid_o (m_axis_tuser_o),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, symbol};

endmodule

// ===== rtl/core/itr_checker.sv =====
// Port-level checker for the Roman numeral converter, bound to the top level.
module itr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // An invalid result stands alone, carries no letter and closes the item
  a_invalid_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == 8'h00))
    else $error("invalid result without tlast or with a letter");

  // A valid letter is one of I V X L C D M
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      (m_axis_tdata_o == 8'h49) || (m_axis_tdata_o == 8'h56) || (m_axis_tdata_o == 8'h58) ||
      (m_axis_tdata_o == 8'h4C) || (m_axis_tdata_o == 8'h43) || (m_axis_tdata_o == 8'h44) ||
      (m_axis_tdata_o == 8'h4D))
    else $error("output letter is not a Roman numeral letter");

  // One item at a time: an input transfer closes the slave side
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  // Hold the output transfer while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("stalled output changed");

endmodule

bind integer_to_roman_numeral_top itr_checker u_itr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
